>>> rtl/rc_pkg.sv
// Shared types and constants for the rotation counter.
// Used by the arithmetic unit and the top level; depends on nothing.
package rc_pkg;

    // Command codes of the input word.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_GYRO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_GYRO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DYNAMIC  = 3'd6;

    // Operations of the shared arithmetic unit.
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // Operand and result widths of the shared unit.
    localparam int OPND_W  = 48;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 52;
    localparam int NUM_W   = 36;
    localparam int DEN_W   = 32;
    localparam int ROOT_W  = 24;
    localparam logic [5:0] DIV_STEPS  = 6'd36;
    localparam logic [5:0] SQRT_STEPS = 6'd24;

    // Filter and rate constants.
    localparam logic [OPND_W-1:0] C_GRAV   = 48'd2621;
    localparam logic [OPND_W-1:0] C_DYN    = 48'd20972;
    localparam logic [OPND_W-1:0] C_GYRO   = 48'd36045;
    localparam logic [OPND_W-1:0] C_KEEP   = 48'd47186;
    localparam logic [OPND_W-1:0] C_NEW    = 48'd18350;
    localparam logic [OPND_W-1:0] RATE_NUM = 48'd9600000;
    localparam logic [OPND_W-1:0] AVG_MUL  = 48'd600000;
    localparam logic [23:0]       MAX24    = 24'hFFFFFF;

    // Request to the shared unit.
    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } rc_alu_req_t;

endpackage

>>> rtl/rc_in_if.sv
// Input channel of the rotation counter: valid/ready and one sample or command word.
// Stand-alone; no package needed.
interface rc_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [31:0]                    time_ms;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
    logic signed [SAMPLE_WIDTH-1:0] gyro_z;

    modport source (output valid, cmd, time_ms, accel_x, accel_y, accel_z, gyro_z,
                    input ready);
    modport sink (input valid, cmd, time_ms, accel_x, accel_y, accel_z, gyro_z,
                  output ready);
endinterface

>>> rtl/rc_out_if.sv
// Output channel of the rotation counter: valid/ready and one report word.
// Stand-alone; no package needed.
interface rc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] elapsed_ms;
    logic [15:0] jump_total;
    logic [15:0] current_rate;
    logic [15:0] average_rate;
    logic [15:0] last_peak_gyro;

    modport source (output valid, elapsed_ms, jump_total, current_rate, average_rate,
                    last_peak_gyro, input ready);
    modport sink (input valid, elapsed_ms, jump_total, current_rate, average_rate,
                  last_peak_gyro, output ready);
endinterface

>>> rtl/rc_alu.sv
// Shared arithmetic unit: signed multiply, restoring divide (36 steps)
// and integer square root (24 steps). Depends on rc_pkg.
module rc_alu (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rc_pkg::rc_alu_req_t       req,
    input  logic [rc_pkg::OPND_W-1:0] a,
    input  logic [rc_pkg::OPND_W-1:0] b,
    output logic                      done,
    output logic [rc_pkg::PROD_W-1:0] result
);
    import rc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [1:0]        op_reg;
    logic [5:0]        cnt_reg;
    logic [OPND_W-1:0] num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic signed [MUL_W-1:0] ma;
    logic signed [MUL_W-1:0] mb;
    logic [DEN_W:0]    div_sh;
    logic              div_ge;
    logic [27:0]       sq_sh;
    logic [27:0]       sq_trial;
    logic              sq_ge;

    assign ma = $signed(a[MUL_W-1:0]);
    assign mb = $signed(b[MUL_W-1:0]);

    // One restoring division step: bring down the next numerator bit.
    assign div_sh = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge = div_sh >= {1'b0, den_reg};

    // One square-root step: bring down two radicand bits, try root*4+1.
    assign sq_sh    = {rem_reg[25:0], num_reg[OPND_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    // Sequencing of the iterations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg <= req.op;
                case (req.op)
                    OP_DIV:
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= DIV_STEPS;
                    end
                    OP_SQRT:
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= SQRT_STEPS;
                    end
                    default:
                    begin
                        done_reg <= 1'b1;
                    end
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            case (req.op)
                OP_DIV:
                begin
                    num_reg <= {{(OPND_W-NUM_W){1'b0}}, a[NUM_W-1:0]};
                    den_reg <= b[DEN_W-1:0];
                    rem_reg <= '0;
                end
                OP_SQRT:
                begin
                    num_reg  <= a;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                default:
                begin
                    prod_reg <= ma * mb;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_DIV)
            begin
                rem_reg <= div_ge ? DEN_W'(div_sh - {1'b0, den_reg}) : div_sh[DEN_W-1:0];
                num_reg <= {num_reg[OPND_W-2:0], div_ge};
            end
            else
            begin
                rem_reg  <= sq_ge ? DEN_W'(sq_sh - sq_trial) : DEN_W'(sq_sh);
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                num_reg  <= {num_reg[OPND_W-3:0], 2'b00};
            end
        end
    end

    assign done = done_reg;

    always_comb
    begin
        case (op_reg)
            OP_MUL:  result = prod_reg;
            OP_DIV:  result = {{(PROD_W-NUM_W){1'b0}}, num_reg[NUM_W-1:0]};
            OP_SQRT: result = {{(PROD_W-ROOT_W){1'b0}}, root_reg};
            default: result = '0;
        endcase
    end

endmodule

>>> rtl/imu_rotation_counter.sv
// Top level of the rotation counter: configuration registers, sequencer and report register.
// Depends on rc_pkg, rc_in_if, rc_out_if and rc_alu.

// Start and stop commands give no report. A sample taken while a session runs
// passes through one shared arithmetic unit under a sequencer: three squares, a
// 24-step square root, three filter multiplies, then, when a counted rotation
// follows the last within the maximum interval, a 36-step rate divide and two
// smoothing multiplies as needed, and, once time has elapsed and a rotation has
// been counted, a multiply and a 36-step divide for the average rate. The input is
// not ready until its report word has been placed in the output register, which
// holds it while the next word is taken in.
module imu_rotation_counter #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rc_in_if.sink                         imu,
    rc_out_if.source                      report,
    input  logic                          cfg_we,
    input  logic [rc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rc_pkg::*;

    localparam int FRAC = 23 - SAMPLE_WIDTH;
    localparam logic [23:0] GRAV_ONE = 24'(32'd4096 << FRAC);
    localparam logic [27:0] REP_HALF = 28'(1) << (9 + FRAC);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_SQZ   = 4'd3;
    localparam logic [3:0] S_ROOT  = 4'd4;
    localparam logic [3:0] S_GRAV  = 4'd5;
    localparam logic [3:0] S_DYN   = 4'd6;
    localparam logic [3:0] S_GYRO  = 4'd7;
    localparam logic [3:0] S_EVENT = 4'd8;
    localparam logic [3:0] S_RDIV  = 4'd9;
    localparam logic [3:0] S_RKEEP = 4'd10;
    localparam logic [3:0] S_RNEW  = 4'd11;
    localparam logic [3:0] S_AVG   = 4'd12;
    localparam logic [3:0] S_AVGM  = 4'd13;
    localparam logic [3:0] S_AVGD  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    // Configuration registers.
    logic [15:0] min_iv_reg, max_iv_reg, timeout_reg, emax_reg;
    logic [14:0] high_reg, low_reg, mind_reg;

    // Control state.
    logic [3:0] state_reg, state_next;
    logic       issued_reg, issued_next;
    logic       running_reg, running_next;
    logic       open_reg, open_next;
    logic       cv_reg, cv_next;
    logic       out_valid_reg, out_valid_next;

    // Datapath state.
    logic [31:0] t_reg, t_next;
    logic [31:0] start_reg, start_next;
    logic signed [SAMPLE_WIDTH-1:0] ax_reg, ay_reg, az_reg, gz_reg;
    logic signed [SAMPLE_WIDTH-1:0] ax_next, ay_next, az_next, gz_next;
    logic [47:0] acc_reg, acc_next;
    logic [23:0] norm_reg, norm_next;
    logic [23:0] grav_reg, grav_next;
    logic [23:0] dynf_reg, dynf_next;
    logic signed [23:0] gyrof_reg, gyrof_next;
    logic [31:0] begin_reg, begin_next;
    logic signed [23:0] pg_reg, pg_next;
    logic [23:0] pd_reg, pd_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] last_reg, last_next;
    logic [23:0] rs_reg, rs_next;
    logic [23:0] r_reg, r_next;
    logic [15:0] iv_reg, iv_next;
    logic [41:0] tmp_reg, tmp_next;
    logic [15:0] avg_reg, avg_next;
    logic [15:0] rep_reg, rep_next;
    logic [31:0] o_elapsed_reg, o_elapsed_next;
    logic [15:0] o_total_reg, o_total_next;
    logic [15:0] o_cur_reg, o_cur_next;
    logic [15:0] o_avg_reg, o_avg_next;
    logic [15:0] o_peak_reg, o_peak_next;

    // Shared unit connections.
    rc_alu_req_t        alu_req;
    logic [OPND_W-1:0]  alu_a, alu_b;
    logic               alu_done;
    logic [PROD_W-1:0]  alu_result;

    rc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_result)
    );

    // Rounded product scaled down by 2^16, as a 24-bit filter step.
    logic signed [PROD_W-1:0] p_rnd;
    logic [23:0]              q24;
    assign p_rnd = $signed(alu_result) + 52'sd32768;
    assign q24   = p_rnd[39:16];

    // Filter differences.
    logic signed [25:0] grav_diff, dyn_diff, gyro_diff, gz_x;
    logic [23:0]        dyn24;
    assign grav_diff = $signed({2'b00, norm_reg}) - $signed({2'b00, grav_reg});
    assign dyn24     = grav_diff[25] ? 24'(-grav_diff) : grav_diff[23:0];
    assign dyn_diff  = $signed({2'b00, dyn24}) - $signed({2'b00, dynf_reg});
    assign gz_x      = 26'(gz_reg) <<< FRAC;
    assign gyro_diff = gz_x - 26'(gyrof_reg);

    // Event detection.
    logic signed [26:0] gyrof27, hi27, lo27, pg27;
    logic signed [23:0] pg_upd;
    logic [23:0]        pd_upd;
    logic [25:0]        mind26;
    logic [31:0]        elapsed, iv_full, since_last;
    logic               ev_close, qualify, acc_ok, rate_path;
    assign gyrof27  = 27'(gyrof_reg);
    assign hi27     = $signed(27'(high_reg) << FRAC);
    assign lo27     = $signed(27'(low_reg) << FRAC);
    assign mind26   = 26'(mind_reg) << FRAC;
    assign pg_upd   = (gyrof_reg > pg_reg) ? gyrof_reg : pg_reg;
    assign pd_upd   = (dynf_reg > pd_reg) ? dynf_reg : pd_reg;
    assign pg27     = 27'(pg_upd);
    assign elapsed  = t_reg - start_reg;
    assign iv_full  = t_reg - last_reg;
    assign since_last = iv_full;
    assign ev_close = open_reg && ((gyrof27 <= lo27) || ((t_reg - begin_reg) >= {16'd0, emax_reg}));
    assign qualify  = ev_close && (pg27 >= hi27) && ({2'b00, pd_upd} >= mind26);
    assign acc_ok   = qualify && (!cv_reg || (iv_full >= {16'd0, min_iv_reg}));
    assign rate_path = acc_ok && cv_reg && (iv_full <= {16'd0, max_iv_reg});

    // Peak report: peak gyro in rad/s times ten, rounded.
    logic [23:0] pg_pos;
    logic [27:0] rep_sum, rep_q;
    logic [15:0] rep_val;
    assign pg_pos  = pg_upd[23] ? 24'd0 : pg_upd;
    assign rep_sum = 28'(pg_pos) * 28'd10 + REP_HALF;
    assign rep_q   = rep_sum >> (10 + FRAC);
    assign rep_val = (|rep_q[27:16]) ? 16'hFFFF : rep_q[15:0];

    // Current rate from the smoothed rate.
    logic [24:0] rs_rnd;
    logic [15:0] cur_val;
    assign rs_rnd  = 25'(rs_reg) + 25'd8;
    assign cur_val = (!cv_reg || (since_last > {16'd0, timeout_reg})) ? 16'd0 :
                     ((|rs_rnd[24:20]) ? 16'hFFFF : rs_rnd[19:4]);

    // Quotient of the average divide, saturated.
    logic [15:0] avg_sat;
    assign avg_sat = (|alu_result[NUM_W-1:16]) ? 16'hFFFF : alu_result[15:0];

    logic in_accept, op_state, out_free;
    assign imu.ready = (state_reg == S_IDLE);
    assign in_accept = imu.valid && imu.ready;
    assign out_free  = !out_valid_reg || report.ready;
    assign op_state  = (state_reg != S_IDLE) && (state_reg != S_EVENT) &&
                       (state_reg != S_AVG) && (state_reg != S_OUT);

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_req.start = op_state && !issued_reg;
        alu_req.op    = OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (state_reg)
            S_SQX:
            begin
                alu_a = 48'(ax_reg);
                alu_b = 48'(ax_reg);
            end
            S_SQY:
            begin
                alu_a = 48'(ay_reg);
                alu_b = 48'(ay_reg);
            end
            S_SQZ:
            begin
                alu_a = 48'(az_reg);
                alu_b = 48'(az_reg);
            end
            S_ROOT:
            begin
                alu_req.op = OP_SQRT;
                alu_a      = acc_reg << (2 * FRAC);
            end
            S_GRAV:
            begin
                alu_a = 48'(grav_diff);
                alu_b = C_GRAV;
            end
            S_DYN:
            begin
                alu_a = 48'(dyn_diff);
                alu_b = C_DYN;
            end
            S_GYRO:
            begin
                alu_a = 48'(gyro_diff);
                alu_b = C_GYRO;
            end
            S_RDIV:
            begin
                alu_req.op = OP_DIV;
                alu_a      = RATE_NUM + 48'(iv_reg >> 1);
                alu_b      = 48'(iv_reg);
            end
            S_RKEEP:
            begin
                alu_a = 48'(rs_reg);
                alu_b = C_KEEP;
            end
            S_RNEW:
            begin
                alu_a = 48'(r_reg);
                alu_b = C_NEW;
            end
            S_AVGM:
            begin
                alu_a = 48'(count_reg);
                alu_b = AVG_MUL;
            end
            S_AVGD:
            begin
                alu_req.op = OP_DIV;
                alu_a      = 48'(tmp_reg) + 48'(elapsed >> 1);
                alu_b      = 48'(elapsed);
            end
            default:
            begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    // Sequencer and state update.
    always_comb
    begin
        state_next     = state_reg;
        issued_next    = issued_reg;
        running_next   = running_reg;
        open_next      = open_reg;
        cv_next        = cv_reg;
        out_valid_next = out_valid_reg;
        t_next         = t_reg;
        start_next     = start_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        gz_next        = gz_reg;
        acc_next       = acc_reg;
        norm_next      = norm_reg;
        grav_next      = grav_reg;
        dynf_next      = dynf_reg;
        gyrof_next     = gyrof_reg;
        begin_next     = begin_reg;
        pg_next        = pg_reg;
        pd_next        = pd_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        rs_next        = rs_reg;
        r_next         = r_reg;
        iv_next        = iv_reg;
        tmp_next       = tmp_reg;
        avg_next       = avg_reg;
        rep_next       = rep_reg;
        o_elapsed_next = o_elapsed_reg;
        o_total_next   = o_total_reg;
        o_cur_next     = o_cur_reg;
        o_avg_next     = o_avg_reg;
        o_peak_next    = o_peak_reg;

        // The report word leaves when taken.
        if (out_valid_reg && report.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (alu_req.start)
        begin
            issued_next = 1'b1;
        end
        if (alu_done)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (imu.cmd)
                        CMD_START:
                        begin
                            running_next = 1'b1;
                            open_next    = 1'b0;
                            cv_next      = 1'b0;
                            start_next   = imu.time_ms;
                            begin_next   = '0;
                            last_next    = '0;
                            grav_next    = GRAV_ONE;
                            dynf_next    = '0;
                            gyrof_next   = '0;
                            pg_next      = '0;
                            pd_next      = '0;
                            count_next   = '0;
                            rep_next     = '0;
                            rs_next      = '0;
                        end
                        CMD_STOP:
                        begin
                            running_next = 1'b0;
                            open_next    = 1'b0;
                        end
                        CMD_SAMPLE:
                        begin
                            if (running_reg)
                            begin
                                t_next     = imu.time_ms;
                                ax_next    = imu.accel_x;
                                ay_next    = imu.accel_y;
                                az_next    = imu.accel_z;
                                gz_next    = imu.gyro_z;
                                state_next = S_SQX;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SQX:
            begin
                if (alu_done)
                begin
                    acc_next   = alu_result[47:0];
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (alu_done)
                begin
                    acc_next   = acc_reg + alu_result[47:0];
                    state_next = S_SQZ;
                end
            end
            S_SQZ:
            begin
                if (alu_done)
                begin
                    acc_next   = acc_reg + alu_result[47:0];
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (alu_done)
                begin
                    norm_next  = alu_result[23:0];
                    state_next = S_GRAV;
                end
            end
            S_GRAV:
            begin
                if (alu_done)
                begin
                    grav_next  = grav_reg + q24;
                    state_next = S_DYN;
                end
            end
            S_DYN:
            begin
                if (alu_done)
                begin
                    dynf_next  = dynf_reg + q24;
                    state_next = S_GYRO;
                end
            end
            S_GYRO:
            begin
                if (alu_done)
                begin
                    gyrof_next = gyrof_reg + $signed(q24);
                    state_next = S_EVENT;
                end
            end
            S_EVENT:
            begin
                state_next = S_AVG;
                if (!open_reg)
                begin
                    if (gyrof27 >= hi27)
                    begin
                        open_next  = 1'b1;
                        begin_next = t_reg;
                        pg_next    = gyrof_reg;
                        pd_next    = dynf_reg;
                    end
                end
                else if (ev_close)
                begin
                    open_next = 1'b0;
                    pg_next   = '0;
                    pd_next   = '0;
                    rep_next  = rep_val;
                end
                else
                begin
                    pg_next = pg_upd;
                    pd_next = pd_upd;
                end
                // A counted rotation, with the rate update it brings.
                if (acc_ok)
                begin
                    if (count_reg != 16'hFFFF)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                    last_next = t_reg;
                    cv_next   = 1'b1;
                    iv_next   = iv_full[15:0];
                    if (!rate_path)
                    begin
                        rs_next = '0;
                    end
                    else if (iv_full != 32'd0)
                    begin
                        state_next = S_RDIV;
                    end
                    else if (rs_reg == 24'd0)
                    begin
                        rs_next = MAX24;
                    end
                    else
                    begin
                        r_next     = MAX24;
                        state_next = S_RKEEP;
                    end
                end
            end
            S_RDIV:
            begin
                if (alu_done)
                begin
                    r_next = alu_result[23:0];
                    if (rs_reg == 24'd0)
                    begin
                        rs_next    = alu_result[23:0];
                        state_next = S_AVG;
                    end
                    else
                    begin
                        state_next = S_RKEEP;
                    end
                end
            end
            S_RKEEP:
            begin
                if (alu_done)
                begin
                    tmp_next   = alu_result[41:0];
                    state_next = S_RNEW;
                end
            end
            S_RNEW:
            begin
                if (alu_done)
                begin
                    rs_next    = 24'((tmp_reg + alu_result[41:0] + 42'd32768) >> 16);
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                if ((elapsed != 32'd0) && (count_reg != 16'd0))
                begin
                    state_next = S_AVGM;
                end
                else
                begin
                    avg_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_AVGM:
            begin
                if (alu_done)
                begin
                    tmp_next   = alu_result[41:0];
                    state_next = S_AVGD;
                end
            end
            S_AVGD:
            begin
                if (alu_done)
                begin
                    avg_next   = avg_sat;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_elapsed_next = elapsed;
                    o_total_next   = count_reg;
                    o_cur_next     = cur_val;
                    o_avg_next     = avg_reg;
                    o_peak_next    = rep_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            running_reg   <= 1'b0;
            open_reg      <= 1'b0;
            cv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            min_iv_reg    <= 16'd200;
            max_iv_reg    <= 16'd1500;
            timeout_reg   <= 16'd1500;
            emax_reg      <= 16'd500;
            high_reg      <= 15'd3584;
            low_reg       <= 15'd1434;
            mind_reg      <= 15'd1024;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            running_reg   <= running_next;
            open_reg      <= open_next;
            cv_reg        <= cv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_INTERVAL: min_iv_reg  <= cfg_data;
                    REG_MAX_INTERVAL: max_iv_reg  <= cfg_data;
                    REG_RATE_TIMEOUT: timeout_reg <= cfg_data;
                    REG_EVENT_MAX:    emax_reg    <= cfg_data;
                    REG_HIGH_GYRO:    high_reg    <= cfg_data[14:0];
                    REG_LOW_GYRO:     low_reg     <= cfg_data[14:0];
                    REG_MIN_DYNAMIC:  mind_reg    <= cfg_data[14:0];
                    default:          min_iv_reg  <= min_iv_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        start_reg     <= start_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        gz_reg        <= gz_next;
        acc_reg       <= acc_next;
        norm_reg      <= norm_next;
        grav_reg      <= grav_next;
        dynf_reg      <= dynf_next;
        gyrof_reg     <= gyrof_next;
        begin_reg     <= begin_next;
        pg_reg        <= pg_next;
        pd_reg        <= pd_next;
        count_reg     <= count_next;
        last_reg      <= last_next;
        rs_reg        <= rs_next;
        r_reg         <= r_next;
        iv_reg        <= iv_next;
        tmp_reg       <= tmp_next;
        avg_reg       <= avg_next;
        rep_reg       <= rep_next;
        o_elapsed_reg <= o_elapsed_next;
        o_total_reg   <= o_total_next;
        o_cur_reg     <= o_cur_next;
        o_avg_reg     <= o_avg_next;
        o_peak_reg    <= o_peak_next;
    end

    assign report.valid          = out_valid_reg;
    assign report.elapsed_ms     = o_elapsed_reg;
    assign report.jump_total     = o_total_reg;
    assign report.current_rate   = o_cur_reg;
    assign report.average_rate   = o_avg_reg;
    assign report.last_peak_gyro = o_peak_reg;

    // The shared unit only finishes work that the sequencer issued.
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> issued_reg)
        else $error("shared unit finished without a pending request");

    // An open event only exists inside a running session.
    a_open_running: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> running_reg)
        else $error("event open while stopped");

    // The count never falls while a sample is being worked on.
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (count_reg >= $past(count_reg)))
        else $error("rotation count decreased during a sample");

    // A pending report word is never dropped.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !report.ready) |=> out_valid_reg)
        else $error("report word lost before it was taken");

endmodule
